// ===== rtl/core/relative_strength_index_defines.svh =====
// Assertion macros
`ifndef RELATIVE_STRENGTH_INDEX_DEFINES_SVH
`define RELATIVE_STRENGTH_INDEX_DEFINES_SVH
`define RSI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define RSI_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/core/rsi_pkg.sv =====
package rsi_pkg;
  localparam int unsigned PriceBitsDef    = 32;
  localparam int unsigned FractionBitsDef = 16;
  localparam int unsigned PeriodBits      = 8;
  localparam int unsigned RsiBits         = 14;
  localparam int unsigned AccBits         = 64; // averages and ratio wrap modulo 2^64
  localparam logic [PeriodBits-1:0] PeriodReset = 8'd14;
  localparam logic [RsiBits-1:0]    RsiFull     = 14'd10000;

  typedef struct packed {
    logic load;   // capture word and do the first step
    logic div_go; // start divider (first or smoothing)
    logic ratio_go;
  } cmd_t;

  typedef struct packed {
    logic trivial;  // result known without division
    logic div_done;
    logic ratio_done;
  } sts_t;
endpackage

// ===== rtl/core/rsi_ctrl.sv =====
`include "relative_strength_index_defines.svh"
module rsi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rsi_pkg::cmd_t  cmd_o,
  input  rsi_pkg::sts_t  sts_i
);
  import rsi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_RATIO = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.trivial) begin
          state_d = S_OUT;
        end else begin
          cmd_o.div_go = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.ratio_go = 1'b1;
          state_d = S_RATIO;
        end
      end
      S_RATIO: begin
        if (sts_i.ratio_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  `RSI_ASSERT(a_load_idle, clk_i, rst_ni, cmd_o.load |-> in_ready_o, "load outside idle")
  `RSI_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o,
              "result dropped")
  `RSI_ASSERT(a_excl, clk_i, rst_ni, !(in_ready_o && out_valid_o), "ready with pending")
endmodule

// ===== rtl/core/rsi_datapath.sv =====
module rsi_datapath #(
  parameter int unsigned PRICE_BITS    = rsi_pkg::PriceBitsDef,
  parameter int unsigned FRACTION_BITS = rsi_pkg::FractionBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rsi_pkg::PeriodBits-1:0] period_i,
  input  logic [PRICE_BITS-1:0]          close_price_i,
  input  logic                           start_of_series_i,
  input  rsi_pkg::cmd_t                  cmd_i,
  output rsi_pkg::sts_t                  sts_o,
  output logic [rsi_pkg::RsiBits-1:0]    rsi_value_o,
  output logic                           rsi_valid_o
);
  import rsi_pkg::*;

  localparam int unsigned AW  = AccBits; // accumulator and ratio width
  localparam int unsigned DCW = $clog2(AW + 1);

  logic [PRICE_BITS-1:0] prev_q;
  logic                  have_q;
  logic [PeriodBits-1:0] seen_q;
  logic [AW-1:0]         gain_q, loss_q;
  logic [PeriodBits-1:0] p_q;
  logic                  trivial_q;
  logic [AW-1:0]         num_g_q, num_l_q;
  logic [AW-1:0]         rem_g_q, rem_l_q, quo_g_q, quo_l_q;
  logic [DCW-1:0]        cnt_q;
  logic                  div_busy_q, ratio_busy_q, done_q, rdone_q;
  logic [AW-1:0]         rn_q, rq_q, rd_q, rr_q;
  logic [RsiBits-1:0]    val_q;
  logic                  vld_q;

  logic [PRICE_BITS-1:0] gain_x, loss_x;
  logic [PeriodBits-1:0] p_eff, n_nxt;
  logic [AW-1:0]         sm_g, sm_l, sum_g, sum_l;
  logic [AW:0]           tg, tl, tr;
  logic                  qbit_r;
  logic                  last_step;

  assign p_eff  = (period_i == '0) ? PeriodBits'(1) : period_i;
  assign gain_x = (close_price_i > prev_q) ? close_price_i - prev_q : '0;
  assign loss_x = (close_price_i > prev_q) ? '0 : prev_q - close_price_i;
  assign n_nxt  = (seen_q == '1) ? seen_q : seen_q + 1'b1;

  // one multiply of avg by (p-1) per channel at load time
  assign sm_g  = gain_q * AW'(p_eff - 1'b1) + (AW'(gain_x) << FRACTION_BITS);
  assign sm_l  = loss_q * AW'(p_eff - 1'b1) + (AW'(loss_x) << FRACTION_BITS);
  assign sum_g = (gain_q + AW'(gain_x)) << FRACTION_BITS;
  assign sum_l = (loss_q + AW'(loss_x)) << FRACTION_BITS;

  // restoring division step
  assign tg        = {rem_g_q, num_g_q[AW-1]};
  assign tl        = {rem_l_q, num_l_q[AW-1]};
  assign tr        = {rr_q, rn_q[AW-1]};
  assign qbit_r    = (tr >= {1'b0, rd_q});
  assign last_step = (cnt_q == DCW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0; have_q <= 1'b0; seen_q <= '0;
      gain_q <= '0; loss_q <= '0; trivial_q <= 1'b0; p_q <= '0;
      num_g_q <= '0; num_l_q <= '0; rem_g_q <= '0; rem_l_q <= '0;
      quo_g_q <= '0; quo_l_q <= '0; cnt_q <= '0;
      rn_q <= '0; rq_q <= '0; rd_q <= '0; rr_q <= '0;
      val_q <= '0; vld_q <= 1'b0;
      div_busy_q <= 1'b0; ratio_busy_q <= 1'b0; done_q <= 1'b0; rdone_q <= 1'b0;
    end else begin
      done_q  <= div_busy_q && last_step;
      rdone_q <= (cmd_i.ratio_go && quo_l_q == '0) || (ratio_busy_q && last_step);
      if (cmd_i.load) begin
        p_q <= p_eff;
        prev_q <= close_price_i;
        have_q <= 1'b1;
        trivial_q <= 1'b1;
        vld_q <= 1'b0;
        val_q <= '0;
        if (start_of_series_i || !have_q) begin
          seen_q <= '0; gain_q <= '0; loss_q <= '0;
        end else begin
          seen_q <= n_nxt;
          if (n_nxt < p_eff) begin
            gain_q <= gain_q + AW'(gain_x);
            loss_q <= loss_q + AW'(loss_x);
          end else begin
            trivial_q <= 1'b0;
            if (n_nxt == p_eff && seen_q < p_eff) begin
              num_g_q <= sum_g; num_l_q <= sum_l;
            end else begin
              num_g_q <= sm_g; num_l_q <= sm_l;
            end
          end
        end
      end
      if (cmd_i.div_go) begin
        div_busy_q <= 1'b1; cnt_q <= DCW'(AW);
        rem_g_q <= '0; rem_l_q <= '0;
      end else if (div_busy_q) begin
        num_g_q <= num_g_q << 1;
        num_l_q <= num_l_q << 1;
        if (tg >= {1'b0, AW'(p_q)}) begin
          rem_g_q <= AW'(tg - {1'b0, AW'(p_q)}); quo_g_q <= {quo_g_q[AW-2:0], 1'b1};
        end else begin
          rem_g_q <= AW'(tg); quo_g_q <= {quo_g_q[AW-2:0], 1'b0};
        end
        if (tl >= {1'b0, AW'(p_q)}) begin
          rem_l_q <= AW'(tl - {1'b0, AW'(p_q)}); quo_l_q <= {quo_l_q[AW-2:0], 1'b1};
        end else begin
          rem_l_q <= AW'(tl); quo_l_q <= {quo_l_q[AW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (last_step) div_busy_q <= 1'b0;
      end
      if (done_q) begin
        gain_q <= quo_g_q; loss_q <= quo_l_q;
      end
      if (cmd_i.ratio_go) begin
        vld_q <= 1'b1;
        if (quo_l_q == '0) begin
          val_q <= RsiFull;
        end else begin
          ratio_busy_q <= 1'b1; cnt_q <= DCW'(AW);
          rn_q <= quo_g_q * AW'(10000);
          rd_q <= quo_g_q + quo_l_q;
          rr_q <= '0;
        end
      end else if (ratio_busy_q) begin
        rn_q <= rn_q << 1;
        if (qbit_r) begin
          rr_q <= AW'(tr - {1'b0, rd_q});
        end else begin
          rr_q <= AW'(tr);
        end
        rq_q <= {rq_q[AW-2:0], qbit_r};
        cnt_q <= cnt_q - 1'b1;
        if (last_step) begin
          ratio_busy_q <= 1'b0;
          val_q <= {rq_q[RsiBits-2:0], qbit_r};
        end
      end
    end
  end

  assign sts_o.trivial    = trivial_q;
  assign sts_o.div_done   = done_q;
  assign sts_o.ratio_done = rdone_q;
  assign rsi_value_o = val_q;
  assign rsi_valid_o = vld_q;
endmodule

// ===== rtl/core/relative_strength_index.sv =====
// Path of a word, taken to result taken: idle, check and output states when no
// RSI is formed; otherwise also the 64-step period divider and, unless the
// average loss is zero, the 64-step ratio divider.
// Handshake: one word at a time; the next word is taken in the cycle after
// the result is taken.
// Reset: asynchronous active-low rst_ni clears history, period returns to 14.
module relative_strength_index #(
  parameter int unsigned PRICE_BITS    = rsi_pkg::PriceBitsDef,
  parameter int unsigned FRACTION_BITS = rsi_pkg::FractionBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rsi_pkg::PeriodBits-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [PRICE_BITS-1:0]          close_price_i,
  input  logic                           start_of_series_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rsi_pkg::RsiBits-1:0]    rsi_value_o,
  output logic                           rsi_valid_o
);
  import rsi_pkg::*;

  logic [PeriodBits-1:0] period_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       period_q <= PeriodReset;
    else if (cfg_we_i) period_q <= cfg_wdata_i;
  end

  rsi_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  rsi_datapath #(.PRICE_BITS(PRICE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk_i, .rst_ni, .period_i(period_q), .close_price_i, .start_of_series_i,
    .cmd_i(cmd), .sts_o(sts), .rsi_value_o, .rsi_valid_o
  );
endmodule

// ===== dv/tb.sv =====
module tb;
  import rsi_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [PeriodBits-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [31:0]           close_price_i;
  logic                  start_of_series_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [RsiBits-1:0]    rsi_value_o;
  logic                  rsi_valid_o;

  relative_strength_index u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .close_price_i    (close_price_i),
    .start_of_series_i(start_of_series_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .rsi_value_o      (rsi_value_o),
    .rsi_valid_o      (rsi_valid_o)
  );

  typedef struct packed {
    logic [RsiBits-1:0] value;
    logic               valid;
  } rsi_res_t;

  localparam int unsigned FracBits = FractionBitsDef;
  localparam longint      CycleLimit = 2_000_000;

  // predictor state
  logic [PeriodBits-1:0] period_reg;
  logic [31:0]           last_close;
  logic                  have_last;
  logic [7:0]            n_changes;
  logic [63:0]           avg_up;
  logic [63:0]           avg_down;

  rsi_res_t rsi_expected_q[$];
  int       fail_count;
  int       words_sent;
  int       results_seen;
  int       valid_seen;
  longint   cycle_count;
  bit       random_idle;
  bit       hold_off;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] wilder_smooth(logic [63:0] avg, logic [63:0] x,
                                                logic [63:0] p);
    return (avg * (p - 64'd1) + (x << FracBits)) / p;
  endfunction

  function automatic rsi_res_t rsi_predict(logic [31:0] price, logic sos);
    rsi_res_t    r;
    logic [63:0] p;
    logic [63:0] up;
    logic [63:0] down;
    logic [8:0]  n;
    r = '0;
    p = (period_reg == 0) ? 64'd1 : 64'(period_reg);
    up = 0;
    down = 0;
    if (sos || !have_last) begin
      last_close = price;
      have_last = 1'b1;
      n_changes = 0;
      avg_up = 0;
      avg_down = 0;
      return r;
    end
    if (price > last_close) up = 64'(price - last_close);
    else down = 64'(last_close - price);
    last_close = price;
    n = 9'(n_changes) + 9'd1;
    if (n > 9'd255) n = 9'd255;
    if (64'(n) < p) begin
      avg_up += up;
      avg_down += down;
    end else if (64'(n) == p && 64'(n_changes) < p) begin
      avg_up = ((avg_up + up) << FracBits) / p;
      avg_down = ((avg_down + down) << FracBits) / p;
      r.valid = 1'b1;
    end else begin
      avg_up = wilder_smooth(avg_up, up, p);
      avg_down = wilder_smooth(avg_down, down, p);
      r.valid = 1'b1;
    end
    n_changes = n[7:0];
    if (r.valid) begin
      if (avg_down == 0) r.value = RsiFull;
      else r.value = RsiBits'((64'd10000 * avg_up) / (avg_up + avg_down));
    end
    return r;
  endfunction

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (rsi_expected_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          rsi_res_t e;
          e = rsi_expected_q.pop_front();
          if (rsi_valid_o) valid_seen++;
          if (e.value !== rsi_value_o) begin
            $error("rsi_value: expected %0d, got %0d", e.value, rsi_value_o);
            fail_count++;
          end
          if (e.valid !== rsi_valid_o) begin
            $error("rsi_valid: expected %0d, got %0d", e.valid, rsi_valid_o);
            fail_count++;
          end
        end
      end
      out_ready_i <= !hold_off && !(random_idle && $urandom_range(99) < 6);
    end
  end

  task automatic send_word(logic [31:0] price, logic sos);
    if (random_idle) begin
      while ($urandom_range(99) < 6) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    close_price_i <= price;
    start_of_series_i <= sos;
    rsi_expected_q.insert(rsi_expected_q.size(), rsi_predict(price, sos));
    words_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (rsi_expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_period(logic [PeriodBits-1:0] p);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    period_reg = p;
  endtask

  task automatic send_series(int len, int unsigned spread);
    logic [31:0] px;
    px = $urandom();
    send_word(px, 1'b1);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(9) == 0) px = $urandom();
      else px = px + $urandom_range(2 * spread) - spread;
      send_word(px, $urandom_range(199) == 0);
    end
  endtask

  task automatic test_directed();
    send_word(32'd0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'd0, 1'b0);
    send_word(32'd0, 1'b0);
    for (int i = 0; i < 14; i++) send_word(32'd100 + i, 1'b0);
    send_word(32'd50, 1'b1);
    write_period(8'd1);
    send_word(32'd50, 1'b0);
    send_word(32'd50, 1'b0);
    send_word(32'd40, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    write_period(8'd0);
    send_word(32'd0, 1'b0);
    send_word(32'd7, 1'b0);
  endtask

  task automatic test_period_sweep();
    logic [PeriodBits-1:0] plist[6] = '{8'd2, 8'd3, 8'd14, 8'd255, 8'd5, 8'd1};
    foreach (plist[k]) begin
      write_period(plist[k]);
      send_series(plist[k] == 8'd255 ? 300 : 90, 1000);
    end
  endtask

  task automatic test_mid_series_change();
    write_period(8'd10);
    send_series(6, 50);
    write_period(8'd3);
    for (int i = 0; i < 8; i++) send_word($urandom(), 1'b0);
    write_period(8'd20);
    for (int i = 0; i < 30; i++) send_word($urandom_range(5000), 1'b0);
  endtask

  task automatic test_backpressure();
    write_period(8'd4);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_series(20, 300);
    join
  endtask

  task automatic test_random();
    random_idle = 1'b0;
    send_series(150, 100000);
    random_idle = 1'b1;
    while (words_sent < 1950) begin
      if ($urandom_range(4) == 0) write_period(PeriodBits'($urandom_range(255)));
      send_series($urandom_range(10, 80), $urandom_range(1, 1 << $urandom_range(31)));
    end
  endtask

  initial begin
    cycle_count = 0;
    fail_count = 0;
    words_sent = 0;
    results_seen = 0;
    valid_seen = 0;
    random_idle = 1'b1;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    close_price_i = '0;
    start_of_series_i = 1'b0;
    out_ready_i = 1'b0;
    period_reg = PeriodReset;
    last_close = 0;
    have_last = 1'b0;
    n_changes = 0;
    avg_up = 0;
    avg_down = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_period_sweep();
    test_mid_series_change();
    test_backpressure();
    test_random();
    drain();

    $display("%0d price words sent, %0d results checked (%0d valid RSI values)",
             words_sent, results_seen, valid_seen);
    $display("periods 0..255 with series restarts, mid-series changes and stalls");
    if (fail_count == 0 && rsi_expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rsi_pkg.sv
rtl/core/rsi_ctrl.sv
rtl/core/rsi_datapath.sv
rtl/core/relative_strength_index.sv
dv/tb.sv
